[rtl/core/utf8_strict_decoder_unit_defines.svh]
// Assertion macros used by the checker file.
`ifndef UTF8_STRICT_DECODER_UNIT_DEFINES_SVH
`define UTF8_STRICT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("u8sd: same-cycle property failed");

// Next-cycle implication, checked outside reset.
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("u8sd: next-cycle property failed");

`endif

[rtl/core/u8sd_pkg.sv]
`default_nettype none

package u8sd_pkg;

  localparam int unsigned PointW = 21;
  localparam int unsigned UnitW  = 16;

  // Lead byte masks and patterns
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;
  localparam logic [7:0] PayMask   = 8'h3F;

  localparam logic [PointW-1:0] MaxPoint  = 21'h10FFFF;
  localparam logic [PointW-1:0] SurrLo    = 21'h00D800;
  localparam logic [PointW-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [PointW-1:0] SuppBase  = 21'h010000;
  localparam logic [PointW-1:0] Min3Point = 21'h000800;
  localparam logic [PointW-1:0] Min2Point = 21'h000080;

  localparam logic [UnitW-1:0] HighSurrBase = 16'hD800;
  localparam logic [UnitW-1:0] LowSurrBase  = 16'hDC00;
  localparam logic [9:0]       TenBitMask   = 10'h3FF;

  // Configuration register index (byte address bit 2)
  localparam logic RegSixteen = 1'b0;

  // One classified character (or a closing reject) between front and back
  typedef struct packed {
    logic [PointW-1:0] cp;
    logic              bad;
    logic              eos;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/u8sd_byte_if.sv]
`default_nettype none

interface u8sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/u8sd_unit_if.sv]
`default_nettype none

interface u8sd_unit_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_unit;
  logic        status;
  logic        end_of_string;

  modport source (output valid, output code_unit, output status, output end_of_string,
                  input ready);
  modport sink   (input valid, input code_unit, input status, input end_of_string,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/utf8_strict_decoder_unit.sv]
// Channel    Dir  Word                                  Handshake
// ---------  ---  ------------------------------------  -----------------
// in_if      in   in_byte[7:0], last_byte                valid / ready
// out_if     out  code_unit[20:0], status, end_of_string valid / ready
// APB        in   sixteen_bit_units at byte address 0    psel/penable/pready
//
// One byte is taken per cycle while the queue has room; its first result word
// passes through the queue write, then the registered output stage, to out_if.
// A code point above U+FFFF in sixteen-bit mode leaves as two words, high
// half first; the back end takes no queue entry while the low half waits.
// in_if.ready drops only while the classifier-to-emitter queue is full.
// Reset clears the string state, the queue and the output stage; mode is 16-bit.
`default_nettype none

module utf8_strict_decoder_unit
  import u8sd_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  u8sd_byte_if.sink        in_if,
  u8sd_unit_if.source      out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  // Configuration register: sixteen_bit_units
  logic   sixteen_q;
  logic   cfg_wr;

  // Front to queue, queue to back
  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sixteen_q <= 1'b1;
    end else if (cfg_wr && paddr[2] == RegSixteen) begin
      sixteen_q <= pwdata[0];
    end
  end

  // Read back the mode bit; other addresses read as zero
  assign prdata = (paddr[2] == RegSixteen) ? {31'b0, sixteen_q} : '0;

  // Classify each byte, gather multi-byte sequences, apply strict checks
  u8sd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .in_byte_i    (in_if.in_byte),
    .last_byte_i  (in_if.last_byte),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  // Short queue of finished characters: lets the emitter stall on its own
  u8sd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  // Emit whole points or UTF-16 units, splitting surrogate pairs
  u8sd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sixteen_i   (sixteen_q),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .code_unit_o (out_if.code_unit),
    .status_o    (out_if.status),
    .eos_o       (out_if.end_of_string)
  );

endmodule

`default_nettype wire

[rtl/core/u8sd_front.sv]
`default_nettype none

module u8sd_front
  import u8sd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output      logic         in_ready_o,
  input  wire logic [7:0]   in_byte_i,
  input  wire logic         last_byte_i,
  output      logic         push_valid_o,
  output      entry_t       push_entry_o,
  input  wire logic         push_ready_i
);

  logic [PointW-1:0] part_q, part_d;
  logic [1:0]        due_q, due_d;
  logic [2:0]        len_q, len_d;
  logic              mal_q, mal_d;
  logic              have;
  logic [PointW-1:0] cp;
  logic [PointW-1:0] gathered;
  logic              accept;

  function automatic logic point_ok(input logic [PointW-1:0] p, input logic [2:0] n);
    logic ok;
    begin
      ok = 1'b1;
      if (n == 3'd2 && p < Min2Point) ok = 1'b0;
      if (n == 3'd3 && p < Min3Point) ok = 1'b0;
      if (n == 3'd4 && p < SuppBase)  ok = 1'b0;
      if (p > MaxPoint) ok = 1'b0;
      if (p >= SurrLo && p <= SurrHi) ok = 1'b0;
      return ok;
    end
  endfunction

  assign accept   = in_valid_i && in_ready_o;
  assign gathered = {part_q[PointW-7:0], in_byte_i[5:0]};

  always_comb begin
    part_d = part_q;
    due_d  = due_q;
    len_d  = len_q;
    mal_d  = mal_q;
    have   = 1'b0;
    cp     = '0;
    if (!mal_q) begin
      if (due_q == 2'd0) begin
        if (!in_byte_i[7]) begin
          cp   = {13'b0, in_byte_i};
          have = 1'b1;
        end else if ((in_byte_i & Lead2Mask) == Lead2Pat) begin
          part_d = {16'b0, in_byte_i[4:0]};
          due_d  = 2'd1;
          len_d  = 3'd2;
        end else if ((in_byte_i & Lead3Mask) == Lead3Pat) begin
          part_d = {17'b0, in_byte_i[3:0]};
          due_d  = 2'd2;
          len_d  = 3'd3;
        end else if ((in_byte_i & Lead4Mask) == Lead4Pat) begin
          part_d = {18'b0, in_byte_i[2:0]};
          due_d  = 2'd3;
          len_d  = 3'd4;
        end else begin
          mal_d = 1'b1;
        end
      end else if ((in_byte_i & ContMask) != ContPat) begin
        mal_d = 1'b1;
      end else begin
        part_d = gathered;
        due_d  = due_q - 2'd1;
        if (due_d == 2'd0) begin
          if (point_ok(gathered, len_q)) begin
            cp   = gathered;
            have = 1'b1;
          end else begin
            mal_d = 1'b1;
          end
          part_d = '0;
          len_d  = '0;
        end
      end
      // cut-off tail
      if (last_byte_i && !mal_d && due_d != 2'd0) mal_d = 1'b1;
    end
  end

  // Hold the byte while the queue is full
  assign in_ready_o        = push_ready_i;
  assign push_valid_o      = accept && (mal_d ? last_byte_i : have);
  assign push_entry_o.cp   = mal_d ? '0 : cp;
  assign push_entry_o.bad  = mal_d;
  assign push_entry_o.eos  = last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      due_q  <= '0;
      len_q  <= '0;
      mal_q  <= 1'b0;
    end else if (accept) begin
      if (last_byte_i) begin
        part_q <= '0;
        due_q  <= '0;
        len_q  <= '0;
        mal_q  <= 1'b0;
      end else begin
        part_q <= part_d;
        due_q  <= due_d;
        len_q  <= len_d;
        mal_q  <= mal_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/u8sd_fifo.sv]
`default_nettype none

module u8sd_fifo
  import u8sd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  input  wire entry_t push_entry_i,
  output      logic   push_ready_o,
  output      logic   pop_valid_o,
  output      entry_t pop_entry_o,
  input  wire logic   pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = slots_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wrap_inc(wr_q);
      if (do_pop)  rd_q <= wrap_inc(rd_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_q] <= push_entry_i;
  end

endmodule

`default_nettype wire

[rtl/core/u8sd_back.sv]
`default_nettype none

module u8sd_back
  import u8sd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              sixteen_i,
  input  wire logic              pop_valid_i,
  input  wire entry_t            pop_entry_i,
  output      logic              pop_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [PointW-1:0] code_unit_o,
  output      logic              status_o,
  output      logic              eos_o
);

  logic              out_valid_q, out_valid_d;
  logic [PointW-1:0] unit_q, unit_d;
  logic              status_q, status_d;
  logic              eos_q, eos_d;
  logic              pend_q, pend_d;
  logic [UnitW-1:0]  pend_unit_q, pend_unit_d;
  logic              pend_eos_q, pend_eos_d;
  logic              load, split;
  logic [PointW-1:0] offset;
  logic [UnitW-1:0]  high_unit, low_unit;

  // Output register is free, or its word leaves this cycle
  assign load        = !out_valid_q || out_ready_i;
  assign pop_ready_o = load && !pend_q;

  assign split     = !pop_entry_i.bad && sixteen_i && (pop_entry_i.cp >= SuppBase);
  assign offset    = pop_entry_i.cp - SuppBase;
  assign high_unit = HighSurrBase | {6'b0, offset[19:10] & TenBitMask};
  assign low_unit  = LowSurrBase | {6'b0, offset[9:0] & TenBitMask};

  always_comb begin
    out_valid_d = out_valid_q;
    unit_d      = unit_q;
    status_d    = status_q;
    eos_d       = eos_q;
    pend_d      = pend_q;
    pend_unit_d = pend_unit_q;
    pend_eos_d  = pend_eos_q;
    if (load) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        unit_d      = {5'b0, pend_unit_q};
        status_d    = 1'b0;
        eos_d       = pend_eos_q;
        pend_d      = 1'b0;
      end else if (pop_valid_i) begin
        out_valid_d = 1'b1;
        if (split) begin
          unit_d      = {5'b0, high_unit};
          status_d    = 1'b0;
          eos_d       = 1'b0;
          pend_d      = 1'b1;
          pend_unit_d = low_unit;
          pend_eos_d  = pop_entry_i.eos;
        end else begin
          unit_d   = pop_entry_i.cp;
          status_d = pop_entry_i.bad;
          eos_d    = pop_entry_i.eos;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q      <= unit_d;
    status_q    <= status_d;
    eos_q       <= eos_d;
    pend_unit_q <= pend_unit_d;
    pend_eos_q  <= pend_eos_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_unit_o = unit_q;
  assign status_o    = status_q;
  assign eos_o       = eos_q;

endmodule

`default_nettype wire

[rtl/core/u8sd_checker.sv]
`default_nettype none
`include "utf8_strict_decoder_unit_defines.svh"

module u8sd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [20:0] code_unit_i,
  input wire logic        status_i,
  input wire logic        eos_i
);

  // Hold a word until it is taken
  `U8SD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A reject carries no code and closes the string
  `U8SD_ASSERT_NOW(a_reject_form, clk_i, rst_ni, out_valid_i && status_i, code_unit_i == 21'd0 && eos_i)

  // Never emit past the last code point
  `U8SD_ASSERT_NOW(a_range, clk_i, rst_ni, out_valid_i, code_unit_i <= 21'h10FFFF)

  // A high surrogate is always followed by its low half in the same string
  `U8SD_ASSERT_NOW(a_high_not_last, clk_i, rst_ni, out_valid_i && !status_i && code_unit_i[20:10] == 11'h036, !eos_i)

endmodule

bind utf8_strict_decoder_unit u8sd_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .code_unit_i (out_if.code_unit),
  .status_i    (out_if.status),
  .eos_i       (out_if.end_of_string)
);

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8sd_pkg::*;

  // Status codes carried on the result channel
  localparam logic StatusOk        = 1'b0;
  localparam logic StatusMalformed = 1'b1;

  // Byte address of the mode register
  localparam logic [2:0] SixteenAddr = {RegSixteen, 2'b00};

  // Cycles to let pass once the last expected word is in, so that bytes which
  // leave no word behind have cleared the queue and the output stage
  localparam int SettleCycles = 20;

  // Hard stop for the whole run
  localparam int CycleLimit = 400000;

  // Boundary code points, picked now and then for well-formed characters
  localparam logic [20:0] BoundaryPoints [9] = '{
    21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
    21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
  };

  // Ways of spoiling a character in a random string
  typedef enum int unsigned {
    FaultBadLead,
    FaultOverlong,
    FaultSurrogate,
    FaultOutOfRange,
    FaultBadCont,
    FaultTruncated,
    FaultRawByte
  } fault_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [20:0] code_unit;
    logic        status;
    logic        eos;
  } unit_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  u8sd_byte_if in_ch ();
  u8sd_unit_if out_ch ();

  utf8_strict_decoder_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bytes waiting for the driver, and the string being put together
  byte_word_t  bytes_pending[$];
  logic [7:0]  str_buf[$];
  int          bytes_queued;

  // Words the decoder still owes us, oldest first
  unit_word_t  units_due[$];

  // Decoder state as we predict it
  logic        sixteen_mode;
  logic [20:0] gathered_point;
  logic [1:0]  conts_due;
  logic [2:0]  seq_len;
  logic        string_bad;

  // Idling controls for each side
  bit          src_idle;
  bit          snk_idle;
  int          send_gap;
  int          sink_stall;

  int          mismatches;
  int          words_seen;
  int          cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Reject overlong forms, surrogates and anything past the last code point.
  function automatic bit point_legal(logic [20:0] cp, logic [2:0] len);
    if (len == 3'd2 && cp < Min2Point) return 1'b0;
    if (len == 3'd3 && cp < Min3Point) return 1'b0;
    if (len == 3'd4 && cp < SuppBase) return 1'b0;
    if (cp > MaxPoint) return 1'b0;
    if (cp >= SurrLo && cp <= SurrHi) return 1'b0;
    return 1'b1;
  endfunction

  function automatic unit_word_t unit_word(logic [20:0] unit, logic status, logic eos);
    unit_word_t w;
    w.code_unit = unit;
    w.status    = status;
    w.eos       = eos;
    return w;
  endfunction

  task automatic clear_string();
    gathered_point = '0;
    conts_due      = '0;
    seq_len        = '0;
    string_bad     = 1'b0;
  endtask

  // Advance the string state by one accepted byte and queue the words it
  // produces.
  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic        have;
    logic [20:0] cp;
    logic [20:0] offs;
    have = 1'b0;
    cp   = '0;
    if (!string_bad) begin
      if (conts_due == 2'd0) begin
        if (!b[7]) begin
          cp   = {13'd0, b};
          have = 1'b1;
        end else if ((b & Lead2Mask) == Lead2Pat) begin
          gathered_point = {16'd0, b[4:0]};
          conts_due      = 2'd1;
          seq_len        = 3'd2;
        end else if ((b & Lead3Mask) == Lead3Pat) begin
          gathered_point = {17'd0, b[3:0]};
          conts_due      = 2'd2;
          seq_len        = 3'd3;
        end else if ((b & Lead4Mask) == Lead4Pat) begin
          gathered_point = {18'd0, b[2:0]};
          conts_due      = 2'd3;
          seq_len        = 3'd4;
        end else begin
          string_bad = 1'b1;
        end
      end else if ((b & ContMask) != ContPat) begin
        string_bad = 1'b1;
      end else begin
        gathered_point = {gathered_point[14:0], b[5:0]};
        conts_due      = conts_due - 2'd1;
        if (conts_due == 2'd0) begin
          if (point_legal(gathered_point, seq_len)) begin
            cp   = gathered_point;
            have = 1'b1;
          end else begin
            string_bad = 1'b1;
          end
          gathered_point = '0;
          seq_len        = '0;
        end
      end
      // a string may not stop inside a sequence
      if (lst && !string_bad && conts_due != 2'd0) string_bad = 1'b1;
    end

    if (string_bad) begin
      if (lst) begin
        units_due.push_back(unit_word('0, StatusMalformed, 1'b1));
        clear_string();
      end
    end else begin
      if (have) begin
        if (sixteen_mode && cp >= SuppBase) begin
          offs = cp - SuppBase;
          units_due.push_back(unit_word(21'(HighSurrBase) + 21'(offs[19:10]), StatusOk, 1'b0));
          units_due.push_back(unit_word(21'(LowSurrBase) + 21'(offs[9:0]), StatusOk, lst));
        end else begin
          units_due.push_back(unit_word(cp, StatusOk, lst));
        end
      end
      if (lst) clear_string();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  // Present bytes from the pending queue; hold a word until it is taken,
  // predict its results at the edge where it goes in.
  always @(posedge clk_i) begin
    byte_word_t nxt;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte, in_ch.last_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (bytes_pending.size() != 0) begin
          nxt = bytes_pending.pop_front();
          in_ch.in_byte   <= nxt.data;
          in_ch.last_byte <= nxt.last;
          in_ch.valid     <= 1'b1;
          send_gap = pick_gap(src_idle);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Take result words, compare each with the oldest expectation and stall
  // the channel at random.
  always @(posedge clk_i) begin
    unit_word_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (units_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d unexpected: unit %h status %b eos %b", words_seen,
                     out_ch.code_unit, out_ch.status, out_ch.end_of_string);
        end else begin
          want = units_due.pop_front();
          if (out_ch.code_unit !== want.code_unit || out_ch.status !== want.status ||
              out_ch.end_of_string !== want.eos) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected unit %h status %b eos %b, got unit %h status %b eos %b",
                       words_seen, want.code_unit, want.status, want.eos,
                       out_ch.code_unit, out_ch.status, out_ch.end_of_string);
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        sink_stall = pick_gap(snk_idle);
      end
    end
  end

  // Stop a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, units_due.size());
      $display("** utf8_strict_decoder_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access and stimulus
  // ---------------------------------------------------------------------------

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where pready is seen high. Call only while the decoder is idle.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SixteenAddr) sixteen_mode = value[0];
  endtask

  // Hold until every byte is in and every word is out, then let the pipe
  // settle.
  task automatic wait_idle();
    while (bytes_pending.size() != 0 || in_ch.valid || units_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Move the assembled string to the driver; flag its final byte if closed.
  task automatic flush_string(input bit closed);
    for (int i = 0; i < str_buf.size(); i++) begin
      bytes_pending.push_back({str_buf[i], closed && (i == str_buf.size() - 1)});
      bytes_queued++;
    end
    str_buf.delete();
  endtask

  // Encode a value with a forced sequence length, legal or not.
  task automatic add_seq(input logic [20:0] cp, input int unsigned len);
    case (len)
      1: str_buf.push_back({1'b0, cp[6:0]});
      2: begin
        str_buf.push_back({3'b110, cp[10:6]});
        str_buf.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_buf.push_back({4'b1110, cp[15:12]});
        str_buf.push_back({2'b10, cp[11:6]});
        str_buf.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_buf.push_back({5'b11110, cp[20:18]});
        str_buf.push_back({2'b10, cp[17:12]});
        str_buf.push_back({2'b10, cp[11:6]});
        str_buf.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic add_char();
    logic [20:0]  cp;
    int unsigned  roll;
    int unsigned  len;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      cp = BoundaryPoints[$urandom_range(0, 8)];
    end else if (roll < 45) begin
      cp = 21'($urandom_range(0, 'h7F));
    end else if (roll < 65) begin
      cp = 21'($urandom_range('h80, 'h7FF));
    end else if (roll < 85) begin
      cp = 21'($urandom_range('h800, 'hFFFF));
      // steer clear of the surrogate block
      if (cp >= SurrLo && cp <= SurrHi) cp = cp ^ 21'h002000;
    end else begin
      cp = 21'($urandom_range('h10000, 'h10FFFF));
    end
    if (cp < Min2Point) len = 1;
    else if (cp < Min3Point) len = 2;
    else if (cp < SuppBase) len = 3;
    else len = 4;
    add_seq(cp, len);
  endtask

  task automatic add_fault();
    fault_kind_e  kind;
    int unsigned  len;
    int unsigned  cut;
    logic [7:0]   b;
    logic [20:0]  lo;
    logic [20:0]  hi;
    kind = fault_kind_e'($urandom_range(0, 6));
    len  = $urandom_range(2, 4);
    case (len)
      2:       begin lo = Min2Point; hi = Min3Point - 21'd1; end
      3:       begin lo = Min3Point; hi = SuppBase - 21'd1;  end
      default: begin lo = SuppBase;  hi = MaxPoint;          end
    endcase
    case (kind)
      FaultBadLead: begin
        if ($urandom_range(0, 1) != 0) b = 8'($urandom_range('h80, 'hBF));
        else b = 8'($urandom_range('hF8, 'hFF));
        str_buf.push_back(b);
      end
      FaultOverlong: add_seq(21'($urandom_range(0, int'(lo) - 1)), len);
      FaultSurrogate: add_seq(21'($urandom_range(int'(SurrLo), int'(SurrHi))), 3);
      FaultOutOfRange: add_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      FaultBadCont, FaultTruncated: begin
        add_seq(21'($urandom_range(int'(lo), int'(hi))), len);
        cut = $urandom_range(1, len - 1);
        repeat (cut) void'(str_buf.pop_back());
        if (kind == FaultBadCont) begin
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[7] = 1'b0;
          str_buf.push_back(b);
        end
      end
      default: str_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // One string of a few characters; about one in four carries a fault,
  // which lands at the tail now and then and so cuts the string short.
  task automatic gen_string(input bit closed);
    int n_chars;
    int fault_at;
    n_chars  = $urandom_range(1, 6);
    fault_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, n_chars - 1)) : -1;
    for (int k = 0; k < n_chars; k++) begin
      if (k == fault_at) add_fault();
      else add_char();
    end
    flush_string(closed);
  endtask

  task automatic fill_random(input int n_bytes);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) gen_string(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // drive every input to a known value before the first edge
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    send_gap        = 0;
    sink_stall      = 0;
    mismatches      = 0;
    words_seen      = 0;
    cycle_count     = 0;
    bytes_queued    = 0;
    sixteen_mode    = 1'b1;
    clear_string();
    src_idle = 1'b1;
    snk_idle = 1'b1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, sixteen-bit units.
    apb_write(SixteenAddr, 32'd1);
    // nul as a plain character, then the first two-byte, the last three-byte
    // and the last four-byte points; the last one splits into a pair
    str_buf = '{8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    flush_string(1'b1);
    // a good unit, then a bad lead; the rest is dropped
    str_buf = '{8'h41, 8'hFF, 8'h80};
    flush_string(1'b1);
    // overlong two-byte form
    str_buf = '{8'hC1, 8'hBF};
    flush_string(1'b1);
    // encoded surrogate
    str_buf = '{8'hED, 8'hA0, 8'h80};
    flush_string(1'b1);
    // one past the last code point
    str_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
    flush_string(1'b1);
    // string cut off after a lead
    str_buf = '{8'hE2};
    flush_string(1'b1);
    // lead followed by something other than a continuation
    str_buf = '{8'hC3, 8'h41};
    flush_string(1'b1);
    wait_idle();

    // Whole code points; leave the last string open across the mode change.
    apb_write(SixteenAddr, 32'd0);
    fill_random(300);
    gen_string(1'b0);
    wait_idle();

    // Sixteen-bit units with both sides running flat out.
    apb_write(SixteenAddr, 32'd1);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    fill_random(300);
    wait_idle();

    // Whole code points again; stop halfway through a four-byte sequence.
    apb_write(SixteenAddr, 32'd0);
    src_idle = 1'b1;
    snk_idle = 1'b1;
    fill_random(300);
    str_buf = '{8'hF0, 8'h9F};
    flush_string(1'b0);
    wait_idle();

    // Finish that character in sixteen-bit mode: it must leave as a pair.
    apb_write(SixteenAddr, 32'd1);
    str_buf = '{8'h98, 8'h80};
    flush_string(1'b1);
    fill_random(325);
    wait_idle();

    if (mismatches == 0) begin
      $display("** utf8_strict_decoder_unit: PASSED **");
    end else begin
      $display("** utf8_strict_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
